// ===== hdl/dda_line_rasterizer_defines.svh =====
// Assertion macros shared by the rasterizer modules.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dda assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dda assertion failed");

`endif

// ===== hdl/dda_pkg.sv =====
package dda_pkg;

  // Defaults for the top-level parameters.
  localparam int FRACTION_BITS_DEF = 16;
  localparam int COORD_BITS_DEF    = 12;

  // Screen size registers.
  localparam int              SCREEN_W     = 12;
  localparam logic [SCREEN_W-1:0] SCREEN_RESET = 12'd1000;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // Operation codes carried in in_tuser.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SLOPE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_line;
    logic div_step;
    logic div_first;
    logic slope_load;
    logic pix_step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic buf_full;
    logic major_nonzero;
  } dp_stat_t;

endpackage

// ===== hdl/dda_div.sv =====
module dda_div #(
  parameter int NUM_W = 12,
  parameter int QUO_W = 17
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic             first,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W:0]   rem_r;
  logic [NUM_W:0]   rem_nxt;
  logic [NUM_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r;
  logic [NUM_W:0]   trial;
  logic             ge;

  // One quotient bit per step; the first step tests the integer bit without a shift.
  always_comb begin
    trial   = first ? rem_r : {rem_r[NUM_W-1:0], 1'b0};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign quo = quo_r;

endmodule

// ===== hdl/dda_ctrl.sv =====
module dda_ctrl #(
  parameter int FRACTION_BITS = dda_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_op,
  output logic               in_tready,
  input  dda_pkg::dp_stat_t  stat,
  output dda_pkg::ctrl_cmd_t cmd
);
  import dda_pkg::*;
  `include "dda_line_rasterizer_defines.svh"

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(FRACTION_BITS);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             start_div;

  // State and bit counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign accept    = in_tvalid && in_tready;
  assign start_div = accept && in_op == OP_START && stat.major_nonzero;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = !stat.buf_full;
        if (in_tvalid && !stat.buf_full) begin
          if (in_op == OP_START) begin
            cmd.load_line = 1'b1;
            if (stat.major_nonzero) begin
              state_nxt = ST_DIV;
              cnt_nxt   = CNT_TOP;
            end
          end else begin
            cmd.pix_step = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == CNT_TOP);
        if (cnt_r == '0) begin
          state_nxt = ST_SLOPE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SLOPE: begin
        cmd.slope_load = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `DDA_ASSERT_NEXT(a_start_divides, start_div, state_r == ST_DIV && cnt_r == CNT_TOP)
  `DDA_ASSERT_NEXT(a_div_ends, state_r == ST_DIV && cnt_r == '0, state_r == ST_SLOPE)
  `DDA_ASSERT_NEXT(a_slope_once, state_r == ST_SLOPE, state_r == ST_IDLE)

endmodule

// ===== hdl/dda_dp.sv =====
module dda_dp #(
  parameter int FRACTION_BITS = dda_pkg::FRACTION_BITS_DEF,
  parameter int COORD_BITS    = dda_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dda_pkg::ctrl_cmd_t                   cmd,
  output dda_pkg::dp_stat_t                    stat,
  // Start fields
  input  logic signed [COORD_BITS-1:0]         start_x,
  input  logic signed [COORD_BITS-1:0]         start_y,
  input  logic signed [COORD_BITS-1:0]         end_x,
  input  logic signed [COORD_BITS-1:0]         end_y,
  input  logic [7:0]                           red_in,
  input  logic [7:0]                           green_in,
  input  logic [7:0]                           blue_in,
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dda_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dda_pkg::SCREEN_W-1:0]         cfg_data,
  // Result buffer head
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_BITS-1:0]         pixel_x,
  output logic signed [COORD_BITS-1:0]         pixel_y,
  output logic [7:0]                           red_out,
  output logic [7:0]                           green_out,
  output logic [7:0]                           blue_out,
  output logic                                 on_screen,
  output logic                                 last_pixel
);
  import dda_pkg::*;
  `include "dda_line_rasterizer_defines.svh"

  localparam int C      = COORD_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int ACC_W  = C + F;
  localparam int SLP_W  = F + 2;
  localparam int QUO_W  = F + 1;
  localparam int CMP_W  = (C > SCREEN_W) ? C : SCREEN_W;
  localparam int PIX_W  = 2 * C + 26;

  // Screen size registers.
  logic [SCREEN_W-1:0] scr_w_r, scr_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_RESET;
      scr_h_r <= SCREEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Start setup: deltas, major axis choice and divider operands.
  logic signed [C:0] dx, dy, dmaj, dmin;
  logic [C-1:0]      adx, ady, amaj, amin;
  logic              x_major_in;

  always_comb begin
    dx         = {end_x[C-1], end_x} - {start_x[C-1], start_x};
    dy         = {end_y[C-1], end_y} - {start_y[C-1], start_y};
    adx        = dx[C] ? C'(-dx) : dx[C-1:0];
    ady        = dy[C] ? C'(-dy) : dy[C-1:0];
    x_major_in = ady <= adx;
    dmaj       = x_major_in ? dx : dy;
    dmin       = x_major_in ? dy : dx;
    amaj       = x_major_in ? adx : ady;
    amin       = x_major_in ? ady : adx;
  end

  assign stat.major_nonzero = amaj != '0;

  logic [QUO_W-1:0] quo;

  dda_div #(
    .NUM_W (C),
    .QUO_W (QUO_W)
  ) u_div (
    .clk   (clk),
    .load  (cmd.load_line),
    .step  (cmd.div_step),
    .first (cmd.div_first),
    .num   (amin),
    .den   (amaj),
    .quo   (quo)
  );

  // Line state.
  logic                    line_active_r;
  logic                    x_major_r;
  logic                    step_down_r;
  logic                    minor_neg_r;
  logic [C-1:0]            major_pos_r;
  logic [C-1:0]            major_end_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [SLP_W-1:0] slope_r;
  logic [23:0]             color_r;

  // Pixel of the current position: the minor coordinate adds one half to the
  // accumulator, then truncates toward zero.
  logic signed [ACC_W:0] rnd;
  logic [ACC_W:0]        rnd_neg;
  logic [C-1:0]          minor_pix;
  logic [C-1:0]          px, py;
  logic                  vis, last;
  logic                  push;

  always_comb begin
    rnd     = {acc_r[ACC_W-1], acc_r} + (ACC_W + 1)'(1 << (F - 1));
    rnd_neg = -rnd;
    if (rnd[ACC_W]) begin
      minor_pix = -rnd_neg[F +: C];
    end else begin
      minor_pix = rnd[F +: C];
    end
    px   = x_major_r ? major_pos_r : minor_pix;
    py   = x_major_r ? minor_pix : major_pos_r;
    vis  = !px[C-1] && !py[C-1]
           && (CMP_W'(px) < CMP_W'(scr_w_r))
           && (CMP_W'(py) < CMP_W'(scr_h_r));
    last = major_pos_r == major_end_r;
    push = cmd.pix_step && line_active_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
    end else if (cmd.load_line) begin
      line_active_r <= 1'b1;
    end else if (push && last) begin
      line_active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      x_major_r   <= x_major_in;
      step_down_r <= dmaj[C];
      minor_neg_r <= dmin[C];
      major_pos_r <= x_major_in ? start_x : start_y;
      major_end_r <= x_major_in ? end_x : end_y;
      acc_r       <= {(x_major_in ? start_y : start_x), {F{1'b0}}};
      slope_r     <= '0;
      color_r     <= {red_in, green_in, blue_in};
    end else begin
      if (cmd.slope_load) begin
        slope_r <= minor_neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      end
      if (push && !last) begin
        major_pos_r <= step_down_r ? (major_pos_r - 1'b1) : (major_pos_r + 1'b1);
        acc_r       <= acc_r + ACC_W'(slope_r);
      end
    end
  end

  // Two-entry result buffer so a step can be taken while a result waits.
  logic [PIX_W-1:0] pix_new, head_r, tail_r;
  logic [1:0]       cnt_r;
  logic             pop;

  assign pix_new   = {last, vis, color_r, py, px};
  assign out_valid = cnt_r != 2'd0;
  assign pop       = out_valid && out_ready;
  assign stat.buf_full = cnt_r == 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if ((cnt_r == 2'd0 && push) || (cnt_r == 2'd1 && pop && push)) begin
      head_r <= pix_new;
    end else if (cnt_r == 2'd2 && pop) begin
      head_r <= tail_r;
    end
    if (push && cnt_r == 2'd1 && !pop) begin
      tail_r <= pix_new;
    end
  end

  assign pixel_x    = head_r[C-1:0];
  assign pixel_y    = head_r[2*C-1:C];
  assign red_out    = head_r[2*C+16 +: 8];
  assign green_out  = head_r[2*C+8 +: 8];
  assign blue_out   = head_r[2*C +: 8];
  assign on_screen  = head_r[2*C+24];
  assign last_pixel = head_r[2*C+25];

  `DDA_ASSERT_SAME(a_buf_bound, 1'b1, cnt_r != 2'd3)
  `DDA_ASSERT_SAME(a_no_push_full, push, cnt_r != 2'd2)
  `DDA_ASSERT_NEXT(a_last_ends_line, push && last && !cmd.load_line, !line_active_r)

endmodule

// ===== hdl/dda_line_rasterizer.sv =====
// Channel  | Direction | Handshake              | Contents
// in_      | input     | in_tvalid/in_tready    | start or step item, endpoints and color
// out_     | output    | out_tvalid/out_tready  | one pixel with on-screen flag and last mark
// cfg_     | input     | cfg_valid/cfg_ready    | screen width or height write
//
// A step item is taken every cycle while the two-entry result buffer has room.
// A start item of nonzero length keeps the input closed until its slope is
// loaded: the slope divider produces one quotient bit per cycle.
// A zero-length start item skips the division. in_tready drops when both
// result entries wait. Reset is synchronous on rst_n; the configuration port
// is always ready.
module dda_line_rasterizer #(
  parameter int FRACTION_BITS = dda_pkg::FRACTION_BITS_DEF,
  parameter int COORD_BITS    = dda_pkg::COORD_BITS_DEF,
  parameter int IN_DATA_W     = ((4 * COORD_BITS + 24 + 7) / 8) * 8,
  parameter int OUT_DATA_W    = ((2 * COORD_BITS + 24 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // start_x, start_y, end_x, end_y, red_in, green_in, blue_in
  input  logic [IN_DATA_W-1:0]          in_tdata,
  // operation
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pixel_x, pixel_y, red_out, green_out, blue_out
  output logic [OUT_DATA_W-1:0]         out_tdata,
  // on_screen
  output logic                          out_tuser,
  // last_pixel
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dda_pkg::SCREEN_W-1:0]  cfg_data
);
  import dda_pkg::*;

  localparam int C = COORD_BITS;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  logic signed [C-1:0] pixel_x, pixel_y;
  logic [7:0]          red_out, green_out, blue_out;

  dda_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dda_dp #(
    .FRACTION_BITS (FRACTION_BITS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .start_x    (in_tdata[0 +: C]),
    .start_y    (in_tdata[C +: C]),
    .end_x      (in_tdata[2*C +: C]),
    .end_y      (in_tdata[3*C +: C]),
    .red_in     (in_tdata[4*C +: 8]),
    .green_in   (in_tdata[4*C+8 +: 8]),
    .blue_in    (in_tdata[4*C+16 +: 8]),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .on_screen  (out_tuser),
    .last_pixel (out_tlast)
  );

  // Pack the result fields, lowest field first, zero padded to whole bytes.
  assign out_tdata = OUT_DATA_W'({blue_out, green_out, red_out, pixel_y, pixel_x});

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import dda_pkg::*;

  localparam int FRAC        = FRACTION_BITS_DEF;
  localparam int CW          = COORD_BITS_DEF;
  localparam int IN_W        = ((4 * CW + 24 + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * CW + 24 + 7) / 8) * 8;
  localparam int CMIN        = -(1 << (CW - 1));
  localparam int CMAX        = (1 << (CW - 1)) - 1;
  localparam int SETTLE      = FRAC + 8;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 300;

  typedef struct {
    logic            op;
    logic [IN_W-1:0] data;
  } line_item_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    logic          vis;
    logic          last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [IN_W-1:0]      in_tdata = '0;
  logic                 in_tuser = OP_START;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
  logic [SCREEN_W-1:0]  cfg_data = '0;

  // Stimulus and scoreboard storage.
  line_item_t line_items[$];
  pixel_t     pending_pixels[$];
  logic       in_taken = 1'b0;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         fail_cnt = 0;
  int         stall_cnt = 0;
  int         gen_w = 1000;
  int         gen_h = 1000;

  // Predicted block state.
  logic [SCREEN_W-1:0] scr_w = SCREEN_RESET;
  logic [SCREEN_W-1:0] scr_h = SCREEN_RESET;
  logic                line_on = 1'b0;
  logic                x_major = 1'b0;
  logic                going_down = 1'b0;
  int                  maj_pos = 0;
  int                  maj_end = 0;
  longint              minor_acc = 0;
  longint              minor_step = 0;
  logic [7:0]          col_r = '0;
  logic [7:0]          col_g = '0;
  logic [7:0]          col_b = '0;

  dda_line_rasterizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < CMIN) ? CMIN : ((v > CMAX) ? CMAX : v);
  endfunction

  // Model one accepted input transfer and queue the pixel it produces, if any.
  task automatic raster_predict(input logic op, input logic [IN_W-1:0] d);
    int     x1, y1, x2, y2, dmaj, dmin, px, py;
    longint mag, rounded, mn;
    pixel_t p;
    if (op == OP_START) begin
      x1 = int'($signed(d[CW-1:0]));
      y1 = int'($signed(d[2*CW-1:CW]));
      x2 = int'($signed(d[3*CW-1:2*CW]));
      y2 = int'($signed(d[4*CW-1:3*CW]));
      x_major = iabs(y2 - y1) <= iabs(x2 - x1);
      if (x_major) begin
        maj_pos   = x1;
        maj_end   = x2;
        minor_acc = longint'(y1) <<< FRAC;
        dmaj      = x2 - x1;
        dmin      = y2 - y1;
      end else begin
        maj_pos   = y1;
        maj_end   = y2;
        minor_acc = longint'(x1) <<< FRAC;
        dmaj      = y2 - y1;
        dmin      = x2 - x1;
      end
      going_down = dmaj < 0;
      // A zero-length line takes no division and keeps a flat slope.
      if (dmaj == 0) begin
        minor_step = 0;
      end else begin
        mag        = (longint'(iabs(dmin)) <<< FRAC) / longint'(iabs(dmaj));
        minor_step = (dmin < 0) ? -mag : mag;
      end
      col_r   = d[4*CW+7:4*CW];
      col_g   = d[4*CW+15:4*CW+8];
      col_b   = d[4*CW+23:4*CW+16];
      line_on = 1'b1;
    end else if (line_on) begin
      // Round the minor coordinate: add one half, then truncate toward zero.
      rounded = minor_acc + (longint'(1) <<< (FRAC - 1));
      mn = (rounded >= 0) ? (rounded >>> FRAC) : -((-rounded) >>> FRAC);
      px = x_major ? maj_pos : int'(mn);
      py = x_major ? int'(mn) : maj_pos;
      p.x    = px[CW-1:0];
      p.y    = py[CW-1:0];
      p.r    = col_r;
      p.g    = col_g;
      p.b    = col_b;
      p.vis  = (px >= 0) && (px < int'(scr_w)) && (py >= 0) && (py < int'(scr_h));
      p.last = (maj_pos == maj_end);
      pending_pixels.insert(pending_pixels.size(), p);
      if (p.last) begin
        line_on = 1'b0;
      end else begin
        maj_pos   = going_down ? maj_pos - 1 : maj_pos + 1;
        minor_acc = minor_acc + minor_step;
      end
    end
  endtask

  // Input driver: present the next queued item once the current one is transferred.
  always @(negedge clk) begin : drive_in
    line_item_t nxt;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (line_items.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = line_items.pop_front();
        in_tuser  <= nxt.op;
        in_tdata  <= nxt.data;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver back-pressure.
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // Monitor: track transfers on every channel and check each pixel in order.
  always @(posedge clk) begin : watch
    pixel_t want, got;
    logic   bad;
    in_taken <= in_tvalid && in_tready;
    if (!rst_n) begin
      scr_w      = SCREEN_RESET;
      scr_h      = SCREEN_RESET;
      line_on    = 1'b0;
      x_major    = 1'b0;
      going_down = 1'b0;
      maj_pos    = 0;
      maj_end    = 0;
      minor_acc  = 0;
      minor_step = 0;
      col_r      = '0;
      col_g      = '0;
      col_b      = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_WIDTH: begin
            scr_w = cfg_data;
          end
          REG_SCREEN_HEIGHT: begin
            scr_h = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        raster_predict(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        got.x    = out_tdata[CW-1:0];
        got.y    = out_tdata[2*CW-1:CW];
        got.r    = out_tdata[2*CW+7:2*CW];
        got.g    = out_tdata[2*CW+15:2*CW+8];
        got.b    = out_tdata[2*CW+23:2*CW+16];
        got.vis  = out_tuser;
        got.last = out_tlast;
        if (pending_pixels.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("unexpected pixel: expected none, actual x=%0d y=%0d",
                     $signed(got.x), $signed(got.y));
          end
        end else begin
          want = pending_pixels.pop_front();
          bad = (want.x !== got.x) || (want.y !== got.y) || (want.r !== got.r) ||
                (want.g !== got.g) || (want.b !== got.b) || (want.vis !== got.vis) ||
                (want.last !== got.last);
          if (bad) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("pixel mismatch: expected x=%0d y=%0d rgb=%h%h%h on=%b last=%b",
                       $signed(want.x), $signed(want.y), want.r, want.g, want.b,
                       want.vis, want.last);
              $display("                actual   x=%0d y=%0d rgb=%h%h%h on=%b last=%b",
                       $signed(got.x), $signed(got.y), got.r, got.g, got.b,
                       got.vis, got.last);
            end
          end
        end
      end
    end
    // Watchdog on cycles without any transfer.
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [23:0] rgb);
    line_item_t it;
    it.op   = OP_START;
    it.data = {rgb[7:0], rgb[15:8], rgb[23:16],
               ey[CW-1:0], ex[CW-1:0], sy[CW-1:0], sx[CW-1:0]};
    line_items.insert(line_items.size(), it);
  endtask

  // Step transfers carry random payload, which the block must disregard.
  task automatic queue_steps(input int n);
    line_item_t  it;
    logic [95:0] junk;
    for (int i = 0; i < n; i++) begin
      junk    = {$urandom, $urandom, $urandom};
      it.op   = OP_STEP;
      it.data = junk[IN_W-1:0];
      line_items.insert(line_items.size(), it);
    end
  endtask

  // Pick a coordinate anywhere, near the origin, or near the far screen edge.
  function automatic int pick_coord(input int edge_pos);
    case ($urandom_range(2))
      0:       return int'($urandom_range(0, 4095)) + CMIN;
      1:       return int'($urandom_range(0, 40)) - 20;
      default: return clamp_coord(edge_pos + int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // Mostly complete lines with random content; some are abandoned part way,
  // and a few stray step transfers land after a line has ended.
  task automatic gen_lines(input int budget);
    int made, sx, sy, ex, ey, span, len, steps;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(99) < 4) begin
        sx = int'($urandom_range(0, 4095)) + CMIN;
        sy = int'($urandom_range(0, 4095)) + CMIN;
        ex = int'($urandom_range(0, 4095)) + CMIN;
        ey = int'($urandom_range(0, 4095)) + CMIN;
      end else begin
        span = ($urandom_range(99) < 8) ? 300 : 24;
        sx = pick_coord(gen_w);
        sy = pick_coord(gen_h);
        ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
        ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
      end
      len   = (iabs(ex - sx) > iabs(ey - sy)) ? iabs(ex - sx) : iabs(ey - sy);
      steps = len + 1;
      if (len > 400) begin
        steps = $urandom_range(0, 24);
      end else if ($urandom_range(99) < 10) begin
        steps = $urandom_range(0, len);
      end
      queue_line(sx, sy, ex, ey, 24'($urandom));
      queue_steps(steps);
      made += 1 + steps;
      if ($urandom_range(99) < 6) begin
        queue_steps($urandom_range(1, 3));
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val[SCREEN_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) begin
      gen_w = val & ((1 << SCREEN_W) - 1);
    end else begin
      gen_h = val & ((1 << SCREEN_W) - 1);
    end
  endtask

  // Wait until every queued item is transferred and every pixel has arrived,
  // then give a pending slope division time to finish.
  task automatic wait_drained();
    while (line_items.size() != 0 || in_tvalid || pending_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    send_idle = 30;
    recv_idle = 48;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines at reset screen size.
    queue_steps(1);
    queue_line(0, 0, 0, 0, 24'h000000);
    queue_steps(1);
    queue_line(CMIN, CMIN, CMAX, CMAX, 24'hFFFFFF);
    queue_steps(3);
    queue_line(CMAX, CMIN, CMIN, CMAX, 24'h80017F);
    queue_steps(2);
    queue_line(998, 999, 1001, 1000, 24'h123456);
    queue_steps(5);
    queue_line(5, 3, 3, -2, 24'hA55AC3);
    queue_steps(6);

    // Random lines; after each half the sender holds off until all pixels are back.
    gen_lines(PHASE_ITEMS / 2);
    wait_drained();
    gen_lines(PHASE_ITEMS / 2);
    wait_drained();

    send_idle = 48;
    recv_idle = 30;
    cfg_write(REG_SCREEN_WIDTH, 1);
    cfg_write(REG_SCREEN_HEIGHT, 2047);
    gen_lines(PHASE_ITEMS);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    cfg_write(REG_SCREEN_WIDTH, 2048);
    cfg_write(REG_SCREEN_HEIGHT, 1);
    gen_lines(PHASE_ITEMS);
    wait_drained();

    cfg_write(REG_SCREEN_WIDTH, $urandom_range(1, 2048));
    cfg_write(REG_SCREEN_HEIGHT, $urandom_range(1, 2048));
    gen_lines(PHASE_ITEMS);
    wait_drained();

    if (fail_cnt == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dda_pkg.sv
hdl/dda_div.sv
hdl/dda_ctrl.sv
hdl/dda_dp.sv
hdl/dda_line_rasterizer.sv
bench/tb_top.sv
